// ----- sv/ordered_dither_gray_quantizer_core_macros.svh -----
// Assertion macros for the ordered-dither gray quantizer checker
`ifndef ORDERED_DITHER_GRAY_QUANTIZER_CORE_MACROS_SVH
`define ORDERED_DITHER_GRAY_QUANTIZER_CORE_MACROS_SVH

// Implication checked only outside reset
`define ODGQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("odgq assertion failed");

// Next-cycle implication checked at every edge, reset included
`define ODGQ_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("odgq assertion failed");

`endif

// ----- sv/odgq_pkg.sv -----
// Package: types, register map and ordered-dither threshold table of the gray quantizer
`default_nettype none

package odgq_pkg;

    typedef enum logic [1:0] {
        MODE_ONE = 2'd0,
        MODE_TWO = 2'd1,
        MODE_N   = 2'd2
    } t_mode;

    localparam int  ADDR_W    = 3;
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LEVEL = 1'b1;

    localparam logic [3:0] LEVEL_BITS_RST = 4'd4;

    localparam logic [5:0] BAYER_TAB [0:63] = '{
        6'd0,  6'd32, 6'd12, 6'd44, 6'd2,  6'd34, 6'd14, 6'd46,
        6'd48, 6'd16, 6'd60, 6'd28, 6'd50, 6'd18, 6'd62, 6'd30,
        6'd8,  6'd40, 6'd4,  6'd36, 6'd10, 6'd42, 6'd6,  6'd38,
        6'd56, 6'd24, 6'd52, 6'd20, 6'd58, 6'd26, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd15, 6'd47, 6'd1,  6'd33, 6'd13, 6'd45,
        6'd51, 6'd19, 6'd63, 6'd31, 6'd49, 6'd17, 6'd61, 6'd29,
        6'd11, 6'd43, 6'd7,  6'd39, 6'd9,  6'd41, 6'd5,  6'd37,
        6'd59, 6'd27, 6'd55, 6'd23, 6'd57, 6'd25, 6'd53, 6'd21
    };

endpackage

`default_nettype wire

// ----- sv/odgq_quant.sv -----
// Gray conversion and ordered-dither quantization of one pixel
`default_nettype none

module odgq_quant (
    input  wire odgq_pkg::t_mode i_mode,
    input  wire logic [3:0]      i_level_bits,
    input  wire logic [23:0]     i_rgb,
    input  wire logic [5:0]      i_thr,
    output logic [7:0]           o_level
);

    logic [7:0]         red, grn, blu;
    logic [9:0]         sum3;
    logic [16:0]        prod;
    logic [7:0]         g_avg;
    logic signed [9:0]  v_low;
    logic [7:0]         res_one, res_two;

    logic [3:0]         bits_c;
    logic [7:0]         w, mask, g_hi;
    logic [9:0]         sum_w;
    logic [7:0]         g_w;
    logic [2:0]         sh;
    logic [14:0]        u, q;
    logic [6:0]         off;
    logic signed [15:0] v_n;
    logic [7:0]         v_clamp, res_n;

    assign red = i_rgb[23:16];
    assign grn = i_rgb[15:8];
    assign blu = i_rgb[7:0];

    // average gray, modes one-bit and two-bit
    assign sum3  = 10'(red) + 10'(grn) + 10'(blu);
    assign prod  = 17'(sum3) * 17'd85;
    assign g_avg = prod[15:8];
    assign v_low = $signed({2'b00, g_avg}) + $signed({4'b0000, i_thr}) - 10'sd33;

    always_comb begin
        if (g_avg < 8'd16) begin
            res_one = 8'd0;
        end else if (g_avg >= 8'd240) begin
            res_one = 8'd1;
        end else if (v_low < 10'sd5) begin
            res_one = 8'd0;
        end else if (v_low >= 10'sd250) begin
            res_one = 8'd1;
        end else begin
            res_one = {7'd0, v_low[7]};
        end
    end

    always_comb begin
        if (g_avg < 8'd5) begin
            res_two = 8'd0;
        end else if (g_avg >= 8'd250) begin
            res_two = 8'd3;
        end else if (v_low < 10'sd5) begin
            res_two = 8'd0;
        end else if (v_low >= 10'sd250) begin
            res_two = 8'd3;
        end else begin
            res_two = {6'd0, v_low[7:6]};
        end
    end

    // weighted gray, n-bit mode
    always_comb begin
        if (i_level_bits < 4'd2) begin
            bits_c = 4'd2;
        end else if (i_level_bits > 4'd8) begin
            bits_c = 4'd8;
        end else begin
            bits_c = i_level_bits;
        end
    end

    assign w     = 8'((9'd1 << bits_c) - 9'd1);
    assign mask  = 8'(w << (4'd8 - bits_c));
    assign g_hi  = 8'd255 - w;
    assign sum_w = 10'(red) + {1'b0, grn, 1'b0} + 10'(blu);
    assign g_w   = sum_w[9:2];
    assign sh    = 3'(bits_c - 4'd2);
    assign u     = (15'(g_w) << sh) + 15'(i_thr) + 15'd31;
    assign q     = u >> sh;
    assign off   = 7'd64 >> sh;
    assign v_n   = $signed({1'b0, q}) - $signed({9'd0, off});

    always_comb begin
        if (v_n > 16'sd255) begin
            v_clamp = 8'd255;
        end else if (v_n < 16'sd0) begin
            v_clamp = 8'd0;
        end else begin
            v_clamp = v_n[7:0];
        end
    end

    always_comb begin
        if (g_w < w) begin
            res_n = 8'd0;
        end else if (g_w >= g_hi) begin
            res_n = mask;
        end else begin
            res_n = v_clamp & mask;
        end
    end

    always_comb begin
        case (i_mode)
            odgq_pkg::MODE_ONE: begin
                o_level = res_one;
            end
            odgq_pkg::MODE_TWO: begin
                o_level = res_two;
            end
            default: begin
                o_level = res_n;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ordered_dither_gray_quantizer_core.sv -----
// Top level of the ordered-dither gray quantizer: input/result registers and APB registers
//
//  channel   direction  signals                               transaction
//  pixel     in         start, busy, i_pixel_rgb/x_pos/y_pos  start high, busy low
//  result    out        o_strobe, o_gray_level                o_strobe high one cycle
//  config    in/out     psel..pready, paddr, pwdata, prdata   APB write, access phase
//
// One pixel per clock; each pixel passes through the input register, then odgq_quant
// and then the result register before its result appears.
// busy is always low. The receiver cannot stall; results are never held.
// Synchronous active-low reset clears the valid flags and the APB registers.
`default_nettype none

module ordered_dither_gray_quantizer_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [23:0]                 i_pixel_rgb,
    input  wire logic [15:0]                 i_x_pos,
    input  wire logic [15:0]                 i_y_pos,
    output logic                             o_strobe,
    output logic [7:0]                       o_gray_level,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [odgq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    odgq_pkg::t_mode r_mode;
    logic [3:0]      r_level_bits;
    logic            r_in_vld;
    logic [23:0]     r_rgb;
    logic [5:0]      r_thr_idx;
    logic            r_out_vld;
    logic [7:0]      r_gray;
    logic [7:0]      n_gray;
    logic            wr_en;
    logic            accept;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= odgq_pkg::MODE_ONE;
            r_level_bits <= odgq_pkg::LEVEL_BITS_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                odgq_pkg::REG_MODE: begin
                    r_mode <= odgq_pkg::t_mode'(pwdata[1:0]);
                end
                odgq_pkg::REG_LEVEL: begin
                    r_level_bits <= pwdata[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            odgq_pkg::REG_MODE: begin
                prdata = {30'd0, r_mode};
            end
            odgq_pkg::REG_LEVEL: begin
                prdata = {28'd0, r_level_bits};
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb     <= i_pixel_rgb;
        r_thr_idx <= {i_y_pos[2:0], i_x_pos[2:0]};
        r_gray    <= n_gray;
    end

    odgq_quant u_quant (
        .i_mode       (r_mode),
        .i_level_bits (r_level_bits),
        .i_rgb        (r_rgb),
        .i_thr        (odgq_pkg::BAYER_TAB[r_thr_idx]),
        .o_level      (n_gray)
    );

    assign o_strobe     = r_out_vld;
    assign o_gray_level = r_gray;

endmodule

`default_nettype wire

// ----- sv/odgq_checker.sv -----
// Port-level checker for the ordered-dither gray quantizer, bound to the top level
`default_nettype none
`include "ordered_dither_gray_quantizer_core_macros.svh"

module odgq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [23:0] i_pixel_rgb,
    input wire logic        o_strobe,
    input wire logic [7:0]  o_gray_level
);

    logic px_acc;

    assign px_acc = start && !busy;

    `ODGQ_ASSERT_IMP(a_result_follows, i_clk, i_rst_n, start && !busy, ##2 o_strobe)
    `ODGQ_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(start && !busy, 2))
    `ODGQ_ASSERT_IMP(a_black_zero, i_clk, i_rst_n, px_acc && ~|i_pixel_rgb, ##2 ~|o_gray_level)
    `ODGQ_ASSERT_NXT(a_reset_quiet, i_clk, !i_rst_n, !o_strobe)

endmodule

bind ordered_dither_gray_quantizer_core odgq_checker u_odgq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_pixel_rgb  (i_pixel_rgb),
    .o_strobe     (o_strobe),
    .o_gray_level (o_gray_level)
);

`default_nettype wire
